### hdl/multi_list_append_splice_unit_macros.svh
// Assertion macros for the list manager port checker.
// Depends on nothing; included by the files that assert.
`ifndef MULTI_LIST_APPEND_SPLICE_UNIT_MACROS_SVH
`define MULTI_LIST_APPEND_SPLICE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MLAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mlas_pkg.sv
// Shared types, codes and sizing helpers for the linked list manager.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mlas_pkg;

    // Fixed port widths
    localparam int LIST_IDX_W = 4;
    localparam int DATA_W     = 32;
    localparam int PTR_W_MAX  = 6;

    // Parameter defaults
    localparam int DEF_NUM_LISTS  = 16;
    localparam int DEF_POOL_NODES = 64;
    localparam int DEF_VALUE_BITS = 32;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DUMP   = 2'd1;
    localparam logic [1:0] OP_SPLICE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_SELF  = 2'd3;

    // Classified command kinds
    typedef enum logic [2:0] {
        K_OK,
        K_FULL,
        K_SELF,
        K_EMPTY,
        K_INSERT,
        K_DUMP,
        K_SPLICE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [LIST_IDX_W-1:0]  tgt;
        logic [LIST_IDX_W-1:0]  src;
        logic [PTR_W_MAX-1:0]   node;
        logic [DATA_W-1:0]      value;
    } cmd_t;

    // Lists reachable through the 4-bit index
    function automatic int list_slots(input int num_lists);
        return (num_lists < (1 << LIST_IDX_W)) ? num_lists : (1 << LIST_IDX_W);
    endfunction

    // Stored value bits; upper bits beyond the port are always zero
    function automatic int store_bits(input int value_bits);
        return (value_bits < DATA_W) ? value_bits : DATA_W;
    endfunction

endpackage

### hdl/mlas_front.sv
// Front end: range checks, self-splice and pool-full detection, node allocation.
// Depends on mlas_pkg; feeds mlas_cmd_queue.
`timescale 1ns / 1ps

module mlas_front
    import mlas_pkg::*;
#(
    parameter int NUM_LISTS  = DEF_NUM_LISTS,
    parameter int POOL_NODES = DEF_POOL_NODES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [1:0]             operation,
    input  logic [LIST_IDX_W-1:0]  list_index,
    input  logic [LIST_IDX_W-1:0]  source_list,
    input  logic [DATA_W-1:0]      value,
    output logic                   push_valid,
    input  logic                   push_ready,
    output cmd_t                   push_cmd
);

    localparam int PW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int CW = PW + 1;
    localparam int LS = list_slots(NUM_LISTS);
    localparam logic [LIST_IDX_W:0] LIST_LIMIT = (LIST_IDX_W + 1)'(LS);
    localparam logic [CW-1:0]       POOL_LIMIT = CW'(POOL_NODES);

    logic [CW-1:0] alloc_reg;
    logic [CW-1:0] alloc_next;
    logic          tgt_ok;
    logic          src_ok;
    logic          pool_full;
    logic          accept;
    cmd_kind_t     kind;

    assign tgt_ok    = {1'b0, list_index} < LIST_LIMIT;
    assign src_ok    = {1'b0, source_list} < LIST_LIMIT;
    assign pool_full = alloc_reg == POOL_LIMIT;

    always_comb
    begin
        unique case (operation)
            OP_INSERT:
            begin
                if (!tgt_ok)
                    kind = K_OK;
                else if (pool_full)
                    kind = K_FULL;
                else
                    kind = K_INSERT;
            end
            OP_DUMP:
            begin
                kind = tgt_ok ? K_DUMP : K_EMPTY;
            end
            OP_SPLICE:
            begin
                if (!tgt_ok || !src_ok)
                    kind = K_OK;
                else if (list_index == source_list)
                    kind = K_SELF;
                else
                    kind = K_SPLICE;
            end
            default:
            begin
                kind = K_OK;
            end
        endcase
    end

    assign accept     = req_valid && push_ready;
    assign req_stall  = !push_ready;
    assign push_valid = req_valid;

    always_comb
    begin
        push_cmd       = '0;
        push_cmd.kind  = kind;
        push_cmd.tgt   = list_index;
        push_cmd.src   = source_list;
        push_cmd.node  = PTR_W_MAX'(alloc_reg[PW-1:0]);
        push_cmd.value = value;
    end

    // Bump allocator: one node per insert, never returned
    assign alloc_next = (accept && kind == K_INSERT) ? alloc_reg + CW'(1) : alloc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alloc_reg <= '0;
        else
            alloc_reg <= alloc_next;
    end

endmodule

### hdl/mlas_cmd_queue.sv
// Two-entry command FIFO between the front end and the execution engine.
// Depends on mlas_pkg.
`timescale 1ns / 1ps

module mlas_cmd_queue
    import mlas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

### hdl/mlas_back.sv
// Execution engine: list head/tail tables, node pool, dump walker, result register.
// Depends on mlas_pkg; fed by mlas_cmd_queue.
`timescale 1ns / 1ps

module mlas_back
    import mlas_pkg::*;
#(
    parameter int NUM_LISTS  = DEF_NUM_LISTS,
    parameter int POOL_NODES = DEF_POOL_NODES,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  cmd_t              pop_cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [DATA_W-1:0] out_value,
    output logic              is_last,
    output logic [1:0]        status
);

    localparam int LS = list_slots(NUM_LISTS);
    localparam int LW = (LS > 1) ? $clog2(LS) : 1;
    localparam int PW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int VW = store_bits(VALUE_BITS);
    localparam logic [PW-1:0] WALK_MAX = PW'(POOL_NODES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_SPL   = 3'd2;
    localparam logic [2:0] S_DHEAD = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;

    // Memories
    logic [PW-1:0] head_mem [LS];
    logic [PW-1:0] tail_mem [LS];
    logic [PW-1:0] next_mem [POOL_NODES];
    logic [VW-1:0] val_mem  [POOL_NODES];

    logic [PW-1:0] head_q;
    logic [PW-1:0] tail_a_q;
    logic [PW-1:0] tail_b_q;
    logic [PW-1:0] next_q;
    logic [VW-1:0] val_q;

    logic          head_rd_en;
    logic [LW-1:0] head_rd_addr;
    logic          tail_rd_en;
    logic [LW-1:0] tail_rd_addr_a;
    logic [LW-1:0] tail_rd_addr_b;
    logic          node_rd_en;
    logic [PW-1:0] node_rd_addr;
    logic          head_wr_en;
    logic [PW-1:0] head_wr_data;
    logic          tail_wr_en;
    logic [PW-1:0] tail_wr_data;
    logic          next_wr_en;
    logic [PW-1:0] next_wr_data;
    logic          val_wr_en;

    // Control and working registers
    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [LS-1:0]     nonempty_reg;
    logic [LS-1:0]     nonempty_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [PW-1:0]     cur_reg;
    logic [PW-1:0]     cur_next;
    logic [PW-1:0]     tail_w_reg;
    logic [PW-1:0]     tail_w_next;
    logic [PW-1:0]     cnt_reg;
    logic [PW-1:0]     cnt_next;

    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [DATA_W-1:0] out_value_reg;
    logic [DATA_W-1:0] out_value_next;
    logic              is_last_reg;
    logic              is_last_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;

    logic              out_free;
    logic [LW-1:0]     q_tgt;
    logic [LW-1:0]     q_src;
    logic [LW-1:0]     c_tgt;
    logic [LW-1:0]     c_src;
    logic [PW-1:0]     c_node;
    logic              walk_last;

    function automatic logic [1:0] imm_status(input cmd_kind_t kind);
        logic [1:0] st;
        unique case (kind)
            K_FULL:          st = ST_FULL;
            K_SELF:          st = ST_SELF;
            K_EMPTY, K_DUMP: st = ST_EMPTY;
            default:         st = ST_OK;
        endcase
        return st;
    endfunction

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign q_tgt     = pop_cmd.tgt[LW-1:0];
    assign q_src     = pop_cmd.src[LW-1:0];
    assign c_tgt     = cmd_reg.tgt[LW-1:0];
    assign c_src     = cmd_reg.src[LW-1:0];
    assign c_node    = cmd_reg.node[PW-1:0];
    assign walk_last = (cur_reg == tail_w_reg) || (cnt_reg == WALK_MAX);

    always_comb
    begin
        state_next     = state_reg;
        nonempty_next  = nonempty_reg;
        cmd_next       = cmd_reg;
        cur_next       = cur_reg;
        tail_w_next    = tail_w_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        out_value_next = out_value_reg;
        is_last_next   = is_last_reg;
        status_next    = status_reg;
        pop_ready      = 1'b0;
        head_rd_en     = 1'b0;
        head_rd_addr   = q_tgt;
        tail_rd_en     = 1'b0;
        tail_rd_addr_a = q_tgt;
        tail_rd_addr_b = q_src;
        node_rd_en     = 1'b0;
        node_rd_addr   = next_q;
        head_wr_en     = 1'b0;
        head_wr_data   = c_node;
        tail_wr_en     = 1'b0;
        tail_wr_data   = c_node;
        next_wr_en     = 1'b0;
        next_wr_data   = c_node;
        val_wr_en      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid && out_free)
                begin
                    pop_ready = 1'b1;
                    cmd_next  = pop_cmd;
                    priority if (pop_cmd.kind == K_INSERT)
                    begin
                        tail_rd_en = 1'b1;
                        state_next = S_INS;
                    end
                    else if (pop_cmd.kind == K_SPLICE)
                    begin
                        head_rd_addr = q_src;
                        head_rd_en   = 1'b1;
                        tail_rd_en   = 1'b1;
                        state_next   = S_SPL;
                    end
                    else if (pop_cmd.kind == K_DUMP && nonempty_reg[q_tgt])
                    begin
                        head_rd_en = 1'b1;
                        tail_rd_en = 1'b1;
                        state_next = S_DHEAD;
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                        out_value_next = '0;
                        is_last_next   = 1'b1;
                        status_next    = imm_status(pop_cmd.kind);
                    end
                end
            end
            S_INS:
            begin
                if (out_free)
                begin
                    val_wr_en = 1'b1;
                    if (nonempty_reg[c_tgt])
                        next_wr_en = 1'b1;
                    else
                        head_wr_en = 1'b1;
                    tail_wr_en           = 1'b1;
                    nonempty_next[c_tgt] = 1'b1;
                    rsp_valid_next       = 1'b1;
                    out_value_next       = '0;
                    is_last_next         = 1'b1;
                    status_next          = ST_OK;
                    state_next           = S_IDLE;
                end
            end
            S_SPL:
            begin
                if (out_free)
                begin
                    if (nonempty_reg[c_src])
                    begin
                        head_wr_data = head_q;
                        next_wr_data = head_q;
                        if (nonempty_reg[c_tgt])
                            next_wr_en = 1'b1;
                        else
                            head_wr_en = 1'b1;
                        tail_wr_data         = tail_b_q;
                        tail_wr_en           = 1'b1;
                        nonempty_next[c_src] = 1'b0;
                        nonempty_next[c_tgt] = 1'b1;
                    end
                    rsp_valid_next = 1'b1;
                    out_value_next = '0;
                    is_last_next   = 1'b1;
                    status_next    = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            S_DHEAD:
            begin
                node_rd_en   = 1'b1;
                node_rd_addr = head_q;
                cur_next     = head_q;
                tail_w_next  = tail_a_q;
                cnt_next     = '0;
                state_next   = S_WALK;
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    out_value_next = DATA_W'(val_q);
                    is_last_next   = walk_last;
                    status_next    = ST_OK;
                    if (walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        node_rd_en = 1'b1;
                        cur_next   = next_q;
                        cnt_next   = cnt_reg + PW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nonempty_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nonempty_reg  <= nonempty_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        cur_reg       <= cur_next;
        tail_w_reg    <= tail_w_next;
        cnt_reg       <= cnt_next;
        out_value_reg <= out_value_next;
        is_last_reg   <= is_last_next;
        status_reg    <= status_next;
    end

    // Head table
    always_ff @(posedge clk)
    begin
        if (head_wr_en)
            head_mem[c_tgt] <= head_wr_data;
        if (head_rd_en)
            head_q <= head_mem[head_rd_addr];
    end

    // Tail table, two read addresses
    always_ff @(posedge clk)
    begin
        if (tail_wr_en)
            tail_mem[c_tgt] <= tail_wr_data;
        if (tail_rd_en)
        begin
            tail_a_q <= tail_mem[tail_rd_addr_a];
            tail_b_q <= tail_mem[tail_rd_addr_b];
        end
    end

    // Node links
    always_ff @(posedge clk)
    begin
        if (next_wr_en)
            next_mem[tail_a_q] <= next_wr_data;
        if (node_rd_en)
            next_q <= next_mem[node_rd_addr];
    end

    // Node values
    always_ff @(posedge clk)
    begin
        if (val_wr_en)
            val_mem[c_node] <= cmd_reg.value[VW-1:0];
        if (node_rd_en)
            val_q <= val_mem[node_rd_addr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign out_value = out_value_reg;
    assign is_last   = is_last_reg;
    assign status    = status_reg;

endmodule

### hdl/multi_list_append_splice_unit.sv
// Flow: an accepted request waits in the command queue, then the engine takes it:
//   ignored/rejected ops go straight to the result register, insert and splice read the
//   tables first, and a dump reads head/tail, then its first node, then walks the rest.
//   One command at a time; insert/splice read, then write the single-write-port memories.
// Reset (rst_n low, async): lists empty, allocator at node 0, queue and result register empty.
//   Memories are not cleared; only written entries are ever used.
`timescale 1ns / 1ps

module multi_list_append_splice_unit
    import mlas_pkg::*;
#(
    parameter int NUM_LISTS  = DEF_NUM_LISTS,
    parameter int POOL_NODES = DEF_POOL_NODES,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    operation,
    input  logic [LIST_IDX_W-1:0]         list_index,
    input  logic [LIST_IDX_W-1:0]         source_list,
    input  logic signed [DATA_W-1:0]      value,
    // Result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic signed [DATA_W-1:0]      out_value,
    output logic                          is_last,
    output logic [1:0]                    status
);

    // Front end -> queue
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;

    // Queue -> execution engine
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    logic [DATA_W-1:0] out_value_raw;

    // Front end: classifies each request transfer. Out-of-range lists,
    // self-splice and pool exhaustion are resolved here, and every insert
    // is handed its node number from the bump allocator, so the engine
    // never has to look at the allocator.
    mlas_front #(
        .NUM_LISTS  (NUM_LISTS),
        .POOL_NODES (POOL_NODES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .list_index  (list_index),
        .source_list (source_list),
        .value       (value),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    // Two-deep command queue: the front keeps taking requests, until both entries
    // are full, while the engine is busy walking a list or waiting on a stalled result.
    mlas_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Engine: one command at a time. Insert reads the target tail, then
    // writes value, link or head, and tail together. Splice reads both
    // tails and the source head, then relinks. Dump reads head/tail,
    // then walks one node per cycle while results are not stalled into
    // the result register, ending at the tail or after POOL_NODES elements.
    mlas_back #(
        .NUM_LISTS  (NUM_LISTS),
        .POOL_NODES (POOL_NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .out_value (out_value_raw),
        .is_last   (is_last),
        .status    (status)
    );

    assign out_value = out_value_raw;

endmodule

### hdl/mlas_checker.sv
// Port-level checker for the list manager, bound to the top level.
// Depends on mlas_pkg and multi_list_append_splice_unit_macros.svh.
`timescale 1ns / 1ps
`include "multi_list_append_splice_unit_macros.svh"

module mlas_checker
    import mlas_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input logic [DATA_W-1:0] out_value,
    input logic              is_last,
    input logic [1:0]        status
);

    // A stalled result stays put until its transfer
    `MLAS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(out_value) && $stable(is_last) && $stable(status), "stalled result changed")

    // Every non-ok status ends the results of its request
    `MLAS_ASSERT_NOW(a_err_last, clk, rst_n, rsp_valid && status != ST_OK, is_last, "non-ok status without is_last")

    // Only dump elements carry data
    `MLAS_ASSERT_NOW(a_err_zero, clk, rst_n, rsp_valid && status != ST_OK, out_value == '0, "non-ok status with nonzero value")

endmodule

bind multi_list_append_splice_unit mlas_checker u_checker (.*);

### bench/list_checker.sv
// Scoreboard for the linked list manager: predicts results from accepted requests.
// Depends on mlas_pkg for port widths, operation and status codes.
`timescale 1ns / 1ps

module list_checker
    import mlas_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_stall,
    input  logic [1:0]                operation,
    input  logic [LIST_IDX_W-1:0]     list_index,
    input  logic [LIST_IDX_W-1:0]     source_list,
    input  logic signed [DATA_W-1:0]  value,
    input  logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  logic signed [DATA_W-1:0]  out_value,
    input  logic                      is_last,
    input  logic [1:0]                status,
    output int                        fail_count,
    output int                        pending_results,
    output int                        results_checked
);

    localparam int LISTS       = DEF_NUM_LISTS;
    localparam int NODES       = DEF_POOL_NODES;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
        logic [1:0]        code;
    } list_result_t;

    list_result_t      expected_q[$];

    // Shadow copy of the list structure
    logic [5:0]        head_ptr  [LISTS];
    logic [5:0]        tail_ptr  [LISTS];
    logic              list_live [LISTS];
    logic [5:0]        link_of   [NODES];
    logic [DATA_W-1:0] node_data [NODES];
    logic [6:0]        alloc_count;

    int                mismatches;
    int                checked;

    function automatic list_result_t make_result(input logic [DATA_W-1:0] data,
                                                 input logic last, input logic [1:0] code);
        list_result_t r;
        r.data = data;
        r.last = last;
        r.code = code;
        return r;
    endfunction

    // Applies one request to the shadow lists and queues the results it causes.
    task automatic apply_list_request(input logic [1:0] op, input logic [3:0] tgt,
                                      input logic [3:0] src, input logic [DATA_W-1:0] val);
        logic [5:0] n;
        logic [5:0] cur;
        logic       stop;
        int         k;
        case (op)
            OP_INSERT:
            begin
                if (alloc_count >= 7'(NODES))
                begin
                    expected_q.push_back(make_result('0, 1'b1, ST_FULL));
                end
                else
                begin
                    n = alloc_count[5:0];
                    alloc_count = alloc_count + 7'd1;
                    node_data[n] = val;
                    link_of[n] = '0;
                    if (!list_live[tgt])
                    begin
                        head_ptr[tgt] = n;
                        list_live[tgt] = 1'b1;
                    end
                    else
                    begin
                        link_of[tail_ptr[tgt]] = n;
                    end
                    tail_ptr[tgt] = n;
                    expected_q.push_back(make_result('0, 1'b1, ST_OK));
                end
            end
            OP_DUMP:
            begin
                if (!list_live[tgt])
                begin
                    expected_q.push_back(make_result('0, 1'b1, ST_EMPTY));
                end
                else
                begin
                    // walk stops at the tail, never past a full pool
                    cur = head_ptr[tgt];
                    stop = 1'b0;
                    k = 0;
                    while (!stop)
                    begin
                        stop = (cur == tail_ptr[tgt]) || (k + 1 >= NODES);
                        expected_q.push_back(make_result(node_data[cur], stop, ST_OK));
                        cur = link_of[cur];
                        k++;
                    end
                end
            end
            OP_SPLICE:
            begin
                if (src == tgt)
                begin
                    expected_q.push_back(make_result('0, 1'b1, ST_SELF));
                end
                else
                begin
                    if (list_live[src])
                    begin
                        if (!list_live[tgt])
                        begin
                            head_ptr[tgt] = head_ptr[src];
                            list_live[tgt] = 1'b1;
                        end
                        else
                        begin
                            link_of[tail_ptr[tgt]] = head_ptr[src];
                        end
                        tail_ptr[tgt] = tail_ptr[src];
                        list_live[src] = 1'b0;
                    end
                    expected_q.push_back(make_result('0, 1'b1, ST_OK));
                end
            end
            default:
            begin
                expected_q.push_back(make_result('0, 1'b1, ST_OK));
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            for (int i = 0; i < LISTS; i++)
            begin
                head_ptr[i] = '0;
                tail_ptr[i] = '0;
                list_live[i] = 1'b0;
            end
            alloc_count = '0;
            mismatches = 0;
            checked = 0;
            fail_count <= 0;
            pending_results <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                apply_list_request(operation, list_index, source_list, value);
            if (rsp_valid && !rsp_stall)
            begin
                checked++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: unexpected result value %h last %b status %0d",
                                 out_value, is_last, status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.data !== out_value || want.last !== is_last
                        || want.code !== status)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"mismatch at result %0d: expected value %h last %b ",
                                      "status %0d, got value %h last %b status %0d"},
                                     checked, want.data, want.last, want.code,
                                     out_value, is_last, status);
                    end
                end
            end
            fail_count <= mismatches;
            pending_results <= expected_q.size();
            results_checked <= checked;
        end
    end

endmodule

### bench/tb_top.sv
// Top of the list manager bench: clock, reset, request stimulus, result stall and verdict.
// Depends on mlas_pkg, multi_list_append_splice_unit and list_checker.
`timescale 1ns / 1ps

module tb_top;
    import mlas_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;  // far beyond the slowest legal run
    localparam int RANDOM_ITEMS = 430;
    localparam int IDLE_PCT     = 31;         // chance per cycle that a side idles
    localparam int HOLD_CYCLES  = 400;        // long result-side hold-off
    localparam int TAIL_CYCLES  = 16;         // settle time after the last result

    // Opcode the block must ignore with a single ok result
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    logic [1:0]                operation = OP_INSERT;
    logic [LIST_IDX_W-1:0]     list_index = '0;
    logic [LIST_IDX_W-1:0]     source_list = '0;
    logic signed [DATA_W-1:0]  value = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    logic signed [DATA_W-1:0]  out_value;
    logic                      is_last;
    logic [1:0]                status;

    int                        fail_count;
    int                        pending_results;
    int                        results_checked;

    // Stimulus controls, written only by the main sequence; the cycle count by the watchdog
    logic                      steady_phase = 1'b0;  // no idling on either side
    int                        hold_epoch = 0;       // bump to start a result hold-off
    int                        op_sent [4];
    int                        cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_list_append_splice_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .list_index  (list_index),
        .source_list (source_list),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .out_value   (out_value),
        .is_last     (is_last),
        .status      (status)
    );

    list_checker CHECKER (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .operation       (operation),
        .list_index      (list_index),
        .source_list     (source_list),
        .value           (value),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .out_value       (out_value),
        .is_last         (is_last),
        .status          (status),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side. A new hold_epoch starts a long stall counted here; otherwise the
    // stall is random, except in the steady phase where results drain freely.
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge clk)
    begin
        if (hold_epoch != hold_seen)
        begin
            hold_seen <= hold_epoch;
            hold_left <= HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (steady_phase)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    // Offers one request and returns at the edge where the transfer happens.
    // Valid is touched at most once per edge: either an idle cycle drops it, or
    // the new payload goes out with valid high.
    task automatic send_request(input logic [1:0] op, input logic [3:0] tgt,
                                input logic [3:0] src, input logic [DATA_W-1:0] val);
        while (!steady_phase && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        operation   <= op;
        list_index  <= tgt;
        source_list <= src;
        value       <= val;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        op_sent[op]++;
    endtask

    // Random request: appends are the most common op so the pool fills and lists grow long;
    // once the pool is exhausted appends keep probing the full status.
    task automatic send_random_request();
        int               pick;
        logic [1:0]       op;
        logic [3:0]       tgt;
        logic [3:0]       src;
        logic [DATA_W-1:0] val;
        pick = $urandom_range(99);
        if (pick < 40)
            op = OP_INSERT;
        else if (pick < 68)
            op = OP_DUMP;
        else if (pick < 94)
            op = OP_SPLICE;
        else
            op = OP_UNUSED;
        tgt = 4'($urandom_range(15));
        // self-splice a bit more often than chance would give
        src = ($urandom_range(7) == 0) ? tgt : 4'($urandom_range(15));
        case ($urandom_range(19))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = 32'h0000_0000;
            3:       val = 32'hffff_ffff;
            default: val = $urandom();
        endcase
        send_request(op, tgt, src, val);
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
            op_sent[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dump, self and empty-source splices, value extremes,
        // splice onto empty and non-empty targets, the unused opcode.
        send_request(OP_DUMP,   4'd0,  4'd0,  32'h0);
        send_request(OP_SPLICE, 4'd1,  4'd1,  32'h0);          // self, empty
        send_request(OP_SPLICE, 4'd3,  4'd2,  32'h0);          // empty source
        send_request(OP_INSERT, 4'd0,  4'd9,  32'h7fff_ffff);
        send_request(OP_INSERT, 4'd0,  4'd0,  32'h8000_0000);
        send_request(OP_INSERT, 4'd15, 4'd15, 32'h0000_0000);
        send_request(OP_INSERT, 4'd15, 4'd0,  32'hffff_ffff);
        send_request(OP_DUMP,   4'd0,  4'd15, 32'h5555_5555);
        send_request(OP_SPLICE, 4'd0,  4'd15, 32'hffff_ffff);  // onto non-empty
        send_request(OP_DUMP,   4'd0,  4'd0,  32'h0);
        send_request(OP_DUMP,   4'd15, 4'd0,  32'h0);          // emptied source
        send_request(OP_SPLICE, 4'd5,  4'd0,  32'h0);          // onto empty
        send_request(OP_SPLICE, 4'd5,  4'd5,  32'h0);          // self, non-empty
        send_request(OP_UNUSED, 4'd10, 4'd5,  32'h1234_5678);
        send_request(OP_INSERT, 4'd15, 4'd3,  32'ha5a5_a5a5);
        send_request(OP_INSERT, 4'd5,  4'd10, 32'h5a5a_5a5a);
        send_request(OP_DUMP,   4'd5,  4'd0,  32'h0);
        send_request(OP_DUMP,   4'd15, 4'd0,  32'h0);
        send_request(OP_DUMP,   4'd0,  4'd0,  32'h0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Long result hold-off while requests keep coming: the block backs up
            // and must stall its request side.
            if (i == 120)
                hold_epoch = hold_epoch + 1;
            if (i == 200)
                steady_phase = 1'b1;
            if (i == 260)
                steady_phase = 1'b0;
            // Quiet the request side until every outstanding result has drained.
            if (i == 320)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
                while (pending_results != 0)
                    @(posedge clk);
            end
            send_random_request();
        end
        req_valid <= 1'b0;
        // let the scoreboard count the last transfer before looking at it
        @(posedge clk);

        while (pending_results != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d appends, %0d dumps, %0d splices, %0d unused opcodes.",
                 op_sent[0] + op_sent[1] + op_sent[2] + op_sent[3],
                 op_sent[OP_INSERT], op_sent[OP_DUMP], op_sent[OP_SPLICE], op_sent[OP_UNUSED]);
        $display("Compared %0d results, %0d mismatched, %0d still outstanding.",
                 results_checked, fail_count, pending_results);
        if (fail_count == 0 && pending_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/mlas_pkg.sv
hdl/mlas_front.sv
hdl/mlas_cmd_queue.sv
hdl/mlas_back.sv
hdl/multi_list_append_splice_unit.sv
hdl/mlas_checker.sv
bench/list_checker.sv
bench/tb_top.sv
